// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion helpers, clocked on a rising edge and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AAR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define AAR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define AAR_ASSERT(lbl, clk, rst_n, prop)
`define AAR_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/aar_pkg.sv =====
package aar_pkg;

  localparam int AXIS_WIDTH_DEF      = 16;
  localparam int ANGLE_WIDTH_DEF     = 16;
  localparam int COEFF_FRAC_BITS_DEF = 14;

  localparam int MAG_W  = 32;
  localparam int SUM_W  = 64;
  localparam int LEN_W  = 32;
  localparam int Q_W    = 31;
  localparam int TURN_W = 32;
  localparam int CS_W   = 32;

  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 31;
  localparam int CORDIC_STEPS = 30;

  localparam int NORM_LAT   = 4;
  localparam int SQRT_LAT   = SQRT_STEPS;
  localparam int DIV_LAT    = DIV_STEPS;
  localparam int CORDIC_LAT = CORDIC_STEPS + 1;
  localparam int MAT_LAT    = 4;
  localparam int TOTAL_LAT  = NORM_LAT + SQRT_LAT + DIV_LAT + MAT_LAT;

  localparam logic signed [CS_W-1:0] CORDIC_K = 32'sd652032874;

  typedef struct packed {
    logic       degen;
    logic [2:0] neg;
  } aar_sgn_t;

  typedef struct packed {
    aar_sgn_t                 sgn;
    logic [TURN_W-1:0]        turn;
    logic [2:0][MAG_W-1:0]    mag;
  } aar_side_t;

endpackage

// ===== hw/rtl/aar_norm.sv =====
module aar_norm
  import aar_pkg::*;
#(
  parameter int AXIS_WIDTH  = AXIS_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  logic [AXIS_WIDTH-1:0]  axis_x_i,
  input  logic [AXIS_WIDTH-1:0]  axis_y_i,
  input  logic [AXIS_WIDTH-1:0]  axis_z_i,
  input  logic [ANGLE_WIDTH-1:0] angle_i,
  output logic                   vld_o,
  output logic [SUM_W-1:0]       sum_o,
  output aar_side_t              side_o
);

  logic [2:0][AXIS_WIDTH-1:0] ax;
  logic [2:0][MAG_W-1:0]      mag_d;
  logic [MAG_W-1:0]           mmax;
  logic [4:0]                 sh_d;
  aar_side_t                  side_d;

  logic [3:0]                 vld_q;
  aar_side_t                  sa_q, sb_q, sc_q, sd_q;
  logic [4:0]                 sh_q;
  logic [2:0][SUM_W-1:0]      sq_q;
  logic [SUM_W-1:0]           sum_q;

  assign ax = {axis_z_i, axis_y_i, axis_x_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [MAG_W:0] a;
      a = (MAG_W+1)'($signed(ax[i]));
      mag_d[i] = a[MAG_W] ? MAG_W'(-a) : MAG_W'(a);
    end
    mmax = mag_d[0];
    if (mag_d[1] > mmax) mmax = mag_d[1];
    if (mag_d[2] > mmax) mmax = mag_d[2];
    sh_d = '0;
    for (int k = 0; k < MAG_W - 1; k++) begin
      if (mmax[k]) sh_d = 5'(MAG_W - 2 - k);
    end
    if (mmax[MAG_W-1]) sh_d = '0;
    side_d.sgn.degen = (mag_d[0] == '0) && (mag_d[1] == '0) && (mag_d[2] == '0);
    side_d.sgn.neg   = {ax[2][AXIS_WIDTH-1], ax[1][AXIS_WIDTH-1], ax[0][AXIS_WIDTH-1]};
    side_d.turn      = TURN_W'(angle_i) << (TURN_W - ANGLE_WIDTH);
    side_d.mag       = mag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q <= side_d;
    sh_q <= sh_d;
    sb_q.sgn  <= sa_q.sgn;
    sb_q.turn <= sa_q.turn;
    for (int i = 0; i < 3; i++) begin
      sb_q.mag[i] <= sa_q.mag[i] << sh_q;
    end
    sc_q <= sb_q;
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= SUM_W'(sb_q.mag[i]) * SUM_W'(sb_q.mag[i]);
    end
    sd_q  <= sc_q;
    sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
  end

  assign vld_o  = vld_q[3];
  assign sum_o  = sum_q;
  assign side_o = sd_q;

endmodule

// ===== hw/rtl/aar_sqrt.sv =====
module aar_sqrt
  import aar_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [SUM_W-1:0] sum_i,
  input  aar_side_t        side_i,
  output logic             vld_o,
  output logic [LEN_W-1:0] len_o,
  output aar_side_t        side_o
);

  logic [SUM_W-1:0]      rad_q  [SQRT_STEPS];
  logic [SUM_W-1:0]      root_q [SQRT_STEPS];
  aar_side_t             side_q [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] vld_q;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [SUM_W-1:0] BitK = SUM_W'(1) << (SUM_W - 2 - 2 * k);
    logic [SUM_W-1:0] rad_in, root_in, trial;
    aar_side_t        side_in;
    logic             vld_in;

    if (k == 0) begin : g_first
      assign rad_in  = sum_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign trial = root_in + BitK;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_in;
      if (rad_in >= trial) begin
        rad_q[k]  <= rad_in - trial;
        root_q[k] <= (root_in >> 1) + BitK;
      end else begin
        rad_q[k]  <= rad_in;
        root_q[k] <= root_in >> 1;
      end
    end
  end

  assign vld_o  = vld_q[SQRT_STEPS-1];
  assign len_o  = root_q[SQRT_STEPS-1][LEN_W-1:0];
  assign side_o = side_q[SQRT_STEPS-1];

endmodule

// ===== hw/rtl/aar_div.sv =====
module aar_div
  import aar_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [LEN_W-1:0]      len_i,
  input  logic [2:0][MAG_W-1:0] mag_i,
  input  aar_sgn_t              sgn_i,
  output logic                  vld_o,
  output logic [2:0][Q_W-1:0]   q_o,
  output aar_sgn_t              sgn_o
);

  localparam int NUM_W = MAG_W + 30 + 1;

  logic [2:0][LEN_W-1:0] rem_q [DIV_STEPS];
  logic [2:0][Q_W-1:0]   nl_q  [DIV_STEPS];
  logic [2:0][Q_W-1:0]   quo_q [DIV_STEPS];
  logic [LEN_W-1:0]      len_q [DIV_STEPS];
  aar_sgn_t              sgn_q [DIV_STEPS];
  logic [DIV_STEPS-1:0]  vld_q;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [2:0][LEN_W-1:0] rem_in;
    logic [2:0][Q_W-1:0]   nl_in, quo_in;
    logic [LEN_W-1:0]      len_in;
    aar_sgn_t              sgn_in;
    logic                  vld_in;

    if (k == 0) begin : g_first
      logic [2:0][NUM_W-1:0] num;
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          num[l]    = (NUM_W'(mag_i[l]) << 30) + NUM_W'(len_i >> 1);
          rem_in[l] = num[l][NUM_W-1:Q_W];
          nl_in[l]  = num[l][Q_W-1:0];
        end
      end
      assign quo_in = '0;
      assign len_in = len_i;
      assign sgn_in = sgn_i;
      assign vld_in = vld_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nl_in  = nl_q[k-1];
      assign quo_in = quo_q[k-1];
      assign len_in = len_q[k-1];
      assign sgn_in = sgn_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      len_q[k] <= len_in;
      sgn_q[k] <= sgn_in;
      for (int l = 0; l < 3; l++) begin
        logic [LEN_W:0] trial;
        logic           ge;
        trial = {rem_in[l], nl_in[l][Q_W-1]};
        ge    = trial >= {1'b0, len_in};
        rem_q[k][l] <= ge ? LEN_W'(trial - {1'b0, len_in}) : trial[LEN_W-1:0];
        nl_q[k][l]  <= nl_in[l] << 1;
        quo_q[k][l] <= {quo_in[l][Q_W-2:0], ge};
      end
    end
  end

  assign vld_o = vld_q[DIV_STEPS-1];
  assign q_o   = quo_q[DIV_STEPS-1];
  assign sgn_o = sgn_q[DIV_STEPS-1];

endmodule

// ===== hw/rtl/aar_cordic.sv =====
module aar_cordic
  import aar_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  logic [TURN_W-1:0]      turn_i,
  output logic                   vld_o,
  output logic signed [CS_W-1:0] x_o,
  output logic signed [CS_W-1:0] y_o,
  output logic                   flip_o
);

  localparam logic [31:0] ATAN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  localparam int Z_W = TURN_W + 1;

  logic signed [CS_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CS_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z_q [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0]  flip_q;
  logic [CORDIC_STEPS:0]  vld_q;

  logic                   flip_d;
  logic [TURN_W-1:0]      p_d;

  assign flip_d = (turn_i[TURN_W-1:TURN_W-2] == 2'b01) || (turn_i[TURN_W-1:TURN_W-2] == 2'b10);
  assign p_d    = flip_d ? turn_i - (TURN_W'(1) << (TURN_W - 1)) : turn_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[CORDIC_STEPS-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= CORDIC_K;
    y_q[0]    <= '0;
    z_q[0]    <= Z_W'($signed(p_d));
    flip_q[0] <= flip_d;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CS_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = Z_W'($signed({1'b0, ATAN[i]}));

    always_ff @(posedge clk_i) begin
      flip_q[i+1] <= flip_q[i];
      if (!z_q[i][Z_W-1]) begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - at;
      end else begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + at;
      end
    end
  end

  assign vld_o  = vld_q[CORDIC_STEPS];
  assign x_o    = x_q[CORDIC_STEPS];
  assign y_o    = y_q[CORDIC_STEPS];
  assign flip_o = flip_q[CORDIC_STEPS];

endmodule

// ===== hw/rtl/aar_mat.sv =====
module aar_mat
  import aar_pkg::*;
#(
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           vld_i,
  input  logic [2:0][Q_W-1:0]            q_i,
  input  aar_sgn_t                       sgn_i,
  input  logic signed [CS_W-1:0]         x_i,
  input  logic signed [CS_W-1:0]         y_i,
  input  logic                           flip_i,
  output logic                           vld_o,
  output logic [8:0][COEFF_FRAC_BITS+1:0] coef_o,
  output logic                           degen_o
);

  localparam int P_W = 36;
  localparam int CW  = COEFF_FRAC_BITS + 2;
  localparam int D   = 30 - COEFF_FRAC_BITS;
  localparam logic signed [P_W-1:0] HALF = (P_W'(1) <<< D) >>> 1;
  localparam logic signed [P_W-1:0] LIM  = P_W'(1) <<< COEFF_FRAC_BITS;

  function automatic logic signed [P_W-1:0] rq30(input logic signed [67:0] p);
    logic signed [67:0] s;
    s = p + 68'sd536870912;
    return P_W'(s >>> 30);
  endfunction

  function automatic logic [CW-1:0] to_coeff(input logic signed [P_W-1:0] v);
    logic signed [P_W-1:0] r;
    r = (v + HALF) >>> D;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return r[CW-1:0];
  endfunction

  logic [3:0]                   vld_q;
  logic [2:0]                   dg_q;
  logic signed [CS_W-1:0]       u_q  [3];
  logic signed [CS_W-1:0]       u1_q [3];
  logic signed [CS_W-1:0]       cs0_q, cs1_q, cs2_q, sn0_q;
  logic signed [CS_W:0]         t_q;
  logic signed [P_W-1:0]        a_q [3];
  logic signed [P_W-1:0]        b_q [3];
  logic signed [P_W-1:0]        b2_q [3];
  logic signed [P_W-1:0]        d_q [3];
  logic signed [P_W-1:0]        txy_q, tyz_q, tzx_q;
  logic [8:0][CW-1:0]           coef_q;
  logic                         deg_q;
  logic [8:0][CW-1:0]           coef_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      logic signed [CS_W-1:0] qs;
      qs = $signed(CS_W'(q_i[r]));
      u_q[r] <= sgn_i.neg[r] ? -qs : qs;
    end
    cs0_q <= flip_i ? -x_i : x_i;
    sn0_q <= flip_i ? -y_i : y_i;
    t_q   <= (CS_W+1)'(33'sd1073741824) - (CS_W+1)'(flip_i ? -x_i : x_i);
    dg_q[0] <= sgn_i.degen;

    for (int r = 0; r < 3; r++) begin
      logic signed [64:0] pt;
      logic signed [63:0] ps;
      pt = t_q * u_q[r];
      ps = u_q[r] * sn0_q;
      a_q[r]  <= rq30(68'(pt));
      b_q[r]  <= rq30(68'(ps));
      u1_q[r] <= u_q[r];
    end
    cs1_q   <= cs0_q;
    dg_q[1] <= dg_q[0];

    for (int r = 0; r < 3; r++) begin
      logic signed [67:0] pd;
      pd = a_q[r] * u1_q[r];
      d_q[r]  <= rq30(pd);
      b2_q[r] <= b_q[r];
    end
    txy_q   <= rq30(a_q[0] * u1_q[1]);
    tyz_q   <= rq30(a_q[1] * u1_q[2]);
    tzx_q   <= rq30(a_q[2] * u1_q[0]);
    cs2_q   <= cs1_q;
    dg_q[2] <= dg_q[1];

    coef_q <= dg_q[2] ? '0 : coef_d;
    deg_q  <= dg_q[2];
  end

  always_comb begin
    coef_d[0] = to_coeff(d_q[0] + P_W'(cs2_q));
    coef_d[1] = to_coeff(txy_q - b2_q[2]);
    coef_d[2] = to_coeff(tzx_q + b2_q[1]);
    coef_d[3] = to_coeff(txy_q + b2_q[2]);
    coef_d[4] = to_coeff(d_q[1] + P_W'(cs2_q));
    coef_d[5] = to_coeff(tyz_q - b2_q[0]);
    coef_d[6] = to_coeff(tzx_q - b2_q[1]);
    coef_d[7] = to_coeff(tyz_q + b2_q[0]);
    coef_d[8] = to_coeff(d_q[2] + P_W'(cs2_q));
  end

  assign vld_o   = vld_q[3];
  assign coef_o  = coef_q;
  assign degen_o = deg_q;

endmodule

// ===== hw/rtl/axis_angle_rotation_matrix.sv =====
// Axis-angle to 3x3 rotation matrix (Rodrigues form), fully pipelined. A transaction
// is taken on any cycle with start high (busy is always low), and its nine row-major
// Q1.F coefficients plus the degenerate flag appear on done_o, one transaction per cycle
// sustained. The latency is set by the 4-stage axis front end, the 32-stage square
// root, the 31-stage divider (the angle CORDIC runs alongside it) and the 4-stage
// matrix product. The receiver cannot stall: every result is shown for one cycle
// only. A zero axis gives an all-zero matrix with degenerate_o set.
`include "assert_macros.svh"

module axis_angle_rotation_matrix
  import aar_pkg::*;
#(
  parameter int AXIS_WIDTH      = AXIS_WIDTH_DEF,
  parameter int ANGLE_WIDTH     = ANGLE_WIDTH_DEF,
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [AXIS_WIDTH-1:0]        axis_x_i,
  input  logic [AXIS_WIDTH-1:0]        axis_y_i,
  input  logic [AXIS_WIDTH-1:0]        axis_z_i,
  input  logic [ANGLE_WIDTH-1:0]       angle_i,
  output logic                         done_o,
  output logic [COEFF_FRAC_BITS+1:0]   r0c0_o,
  output logic [COEFF_FRAC_BITS+1:0]   r0c1_o,
  output logic [COEFF_FRAC_BITS+1:0]   r0c2_o,
  output logic [COEFF_FRAC_BITS+1:0]   r1c0_o,
  output logic [COEFF_FRAC_BITS+1:0]   r1c1_o,
  output logic [COEFF_FRAC_BITS+1:0]   r1c2_o,
  output logic [COEFF_FRAC_BITS+1:0]   r2c0_o,
  output logic [COEFF_FRAC_BITS+1:0]   r2c1_o,
  output logic [COEFF_FRAC_BITS+1:0]   r2c2_o,
  output logic                         degenerate_o
);

  localparam int CoefLim = 1 << COEFF_FRAC_BITS;

  logic                                nrm_vld, sq_vld, dv_vld, cr_vld;
  logic [SUM_W-1:0]                    nrm_sum;
  aar_side_t                           nrm_side, sq_side;
  logic [LEN_W-1:0]                    sq_len;
  logic [2:0][Q_W-1:0]                 dv_q;
  aar_sgn_t                            dv_sgn;
  logic signed [CS_W-1:0]              cr_x, cr_y;
  logic                                cr_flip;
  logic [8:0][COEFF_FRAC_BITS+1:0]     coef;
  logic                                any_coef;

  assign busy = 1'b0;

  aar_norm #(
    .AXIS_WIDTH (AXIS_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (start && !busy),
    .axis_x_i(axis_x_i),
    .axis_y_i(axis_y_i),
    .axis_z_i(axis_z_i),
    .angle_i (angle_i),
    .vld_o   (nrm_vld),
    .sum_o   (nrm_sum),
    .side_o  (nrm_side)
  );

  aar_sqrt u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (nrm_vld),
    .sum_i (nrm_sum),
    .side_i(nrm_side),
    .vld_o (sq_vld),
    .len_o (sq_len),
    .side_o(sq_side)
  );

  aar_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (sq_vld),
    .len_i (sq_len),
    .mag_i (sq_side.mag),
    .sgn_i (sq_side.sgn),
    .vld_o (dv_vld),
    .q_o   (dv_q),
    .sgn_o (dv_sgn)
  );

  aar_cordic u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (sq_vld),
    .turn_i(sq_side.turn),
    .vld_o (cr_vld),
    .x_o   (cr_x),
    .y_o   (cr_y),
    .flip_o(cr_flip)
  );

  aar_mat #(
    .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
  ) u_mat (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (dv_vld),
    .q_i    (dv_q),
    .sgn_i  (dv_sgn),
    .x_i    (cr_x),
    .y_i    (cr_y),
    .flip_i (cr_flip),
    .vld_o  (done_o),
    .coef_o (coef),
    .degen_o(degenerate_o)
  );

  assign r0c0_o = coef[0];
  assign r0c1_o = coef[1];
  assign r0c2_o = coef[2];
  assign r1c0_o = coef[3];
  assign r1c1_o = coef[4];
  assign r1c2_o = coef[5];
  assign r2c0_o = coef[6];
  assign r2c1_o = coef[7];
  assign r2c2_o = coef[8];

  assign any_coef = |coef;

  `AAR_ASSERT(a_degen_zero, clk_i, rst_ni, done_o && degenerate_o |-> !any_coef)
  `AAR_ASSERT(a_latency, clk_i, rst_ni, start && !busy |-> ##TOTAL_LAT done_o)
  `AAR_ASSERT(a_diag_range, clk_i, rst_ni, done_o |-> ($signed(r1c1_o) <= CoefLim) && ($signed(r1c1_o) >= -CoefLim))
  `AAR_ASSERT_NEVER(a_branch_skew, clk_i, rst_ni, dv_vld != cr_vld)

endmodule
